// ----- design/nhm_pkg.sv -----
// ---------------------------------------------------------------------------
// nhm_pkg
// Shared types, codes and reset values for the node health monitor table.
// ---------------------------------------------------------------------------
package nhm_pkg;

   localparam int unsigned SLOTS_DEF = 16;

   localparam logic [1:0] OP_HEARTBEAT = 2'd0;
   localparam logic [1:0] OP_SILENCE   = 2'd1;
   localparam logic [1:0] OP_QUERY     = 2'd2;
   localparam logic [1:0] OP_RESERVED  = 2'd3;

   localparam logic [2:0] KIND_QUERY     = 3'd0;
   localparam logic [2:0] KIND_ONLINE    = 3'd1;
   localparam logic [2:0] KIND_RECOVERED = 3'd5;
   localparam logic [2:0] KIND_REBOOT    = 3'd6;
   localparam logic [2:0] KIND_SILENT    = 3'd7;

   localparam logic [2:0] CSR_HIBERNATE = 3'd0;
   localparam logic [2:0] CSR_CRITICAL  = 3'd1;
   localparam logic [2:0] CSR_WARNING   = 3'd2;
   localparam logic [2:0] CSR_HYST      = 3'd3;
   localparam logic [2:0] CSR_RB_LIMIT  = 3'd4;
   localparam logic [2:0] CSR_RB_WINDOW = 3'd5;
   localparam logic [2:0] CSR_SILENCE   = 3'd6;

   localparam logic [15:0] HIBERNATE_RST = 16'd330;
   localparam logic [15:0] CRITICAL_RST  = 16'd340;
   localparam logic [15:0] WARNING_RST   = 16'd360;
   localparam logic [15:0] HYST_RST      = 16'd10;
   localparam logic [15:0] RB_LIMIT_RST  = 16'd5;
   localparam logic [31:0] RB_WINDOW_RST = 32'd86400000;
   localparam logic [31:0] SILENCE_RST   = 32'd600000;

   // compare steps of the shared unit
   localparam logic [2:0] CS_HIB       = 3'd0;
   localparam logic [2:0] CS_CRIT      = 3'd1;
   localparam logic [2:0] CS_WARN      = 3'd2;
   localparam logic [2:0] CS_WARN_UP   = 3'd3;
   localparam logic [2:0] CS_CRIT_UP   = 3'd4;
   localparam logic [2:0] CS_WINDOW    = 3'd5;
   localparam logic [2:0] CS_REBOOT    = 3'd6;
   localparam logic [2:0] CS_SILENCE   = 3'd7;

   typedef struct packed {
      logic [15:0] hibernate;
      logic [15:0] critical;
      logic [15:0] warning;
      logic [15:0] hyst;
      logic [15:0] rb_limit;
      logic [31:0] rb_window;
      logic [31:0] silence;
   } cfg_type;

   typedef struct packed {
      logic [31:0] node;
      logic [31:0] heard;
      logic [1:0]  level;
      logic        silent;
      logic        seen;
      logic [31:0] win_start;
      logic [15:0] rb_base;
      logic        anom;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_FETCH,
      ST_CMP,
      ST_EVAL,
      ST_EMIT
   } state_type;

endpackage

// ----- design/nhm_req_if.sv -----
// ---------------------------------------------------------------------------
// nhm_req_if
// Request channel: valid/ready handshake with one request item.
// ---------------------------------------------------------------------------
interface nhm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] node_id;
   logic [15:0] battery_cv;
   logic [15:0] reboot_total;
   logic [31:0] now_ms;

   modport source (output valid, opcode, node_id, battery_cv, reboot_total, now_ms,
                   input ready);
   modport sink (input valid, opcode, node_id, battery_cv, reboot_total, now_ms,
                 output ready);
endinterface

// ----- design/nhm_rsp_if.sv -----
// ---------------------------------------------------------------------------
// nhm_rsp_if
// Result channel: valid/ready handshake with one alert item.
// ---------------------------------------------------------------------------
interface nhm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  alert_kind;
   logic [31:0] alert_node;
   logic [15:0] alert_arg;
   logic [31:0] alert_time_ms;
   logic [31:0] heard_ms;
   logic        last_of_run;

   modport source (output valid, alert_kind, alert_node, alert_arg, alert_time_ms,
                   heard_ms, last_of_run, input ready);
   modport sink (input valid, alert_kind, alert_node, alert_arg, alert_time_ms,
                 heard_ms, last_of_run, output ready);
endinterface

// ----- design/nhm_cmp.sv -----
// ---------------------------------------------------------------------------
// nhm_cmp
// Shared compare unit: picks the operands of one step and forms a < b.
// ---------------------------------------------------------------------------
module nhm_cmp
   import nhm_pkg::*;
(
   input  logic [2:0]  step,
   input  cfg_type     cfg,
   input  logic [15:0] cv,
   input  logic [15:0] rb,
   input  logic [31:0] now,
   input  entry_type   ent,
   output logic        lt
);

   logic [32:0] op_a;
   logic [32:0] op_b;
   logic [31:0] diff;

   always_comb begin
      diff = 32'd0;
      op_a = {17'd0, cv};
      op_b = 33'd0;
      case (step)
         CS_HIB:     op_b = {17'd0, cfg.hibernate};
         CS_CRIT:    op_b = {17'd0, cfg.critical};
         CS_WARN:    op_b = {17'd0, cfg.warning};
         CS_WARN_UP: op_b = {16'd0, {1'b0, cfg.warning} + {1'b0, cfg.hyst}};
         CS_CRIT_UP: op_b = {16'd0, {1'b0, cfg.critical} + {1'b0, cfg.hyst}};
         CS_WINDOW: begin
            // window expired when window < now - start
            diff = now - ent.win_start;
            op_a = {1'b0, cfg.rb_window};
            op_b = {1'b0, diff};
         end
         CS_REBOOT: begin
            op_a = {17'd0, cfg.rb_limit};
            op_b = {17'd0, rb - ent.rb_base};
         end
         default: begin
            diff = now - ent.heard;
            op_a = {1'b0, cfg.silence};
            op_b = {1'b0, diff};
         end
      endcase
   end

   assign lt = op_a < op_b;

endmodule

// ----- design/node_health_monitor_table_core.sv -----
// ---------------------------------------------------------------------------
// node_health_monitor_table_core
// Slot table of remote nodes: heartbeat tracking, battery level, reboot
// anomaly, silence detection and last-heard query.
//
//   channel | dir | handshake         | payload
//   req     | in  | valid/ready       | opcode, node_id, battery_cv, reboot_total, now_ms
//   rsp     | out | valid/ready       | alert_kind, alert_node, alert_arg, alert_time_ms,
//           |     |                   | heard_ms, last_of_run
//   csr     | in  | write enable only | csr_index, csr_wdata
//
// An item runs a table scan (each slot read in ST_SCAN_RD, compared in
// ST_SCAN_CMP), one fetch, 8 compare steps on the shared comparator, one update,
// then one result beat per cycle (up to 3) while rsp.ready is high; items for
// unknown nodes may skip fetch and compares. Items with node id 0 or opcode 3 are
// dropped in ST_IDLE. Reset clears the slot valid bits at once; no clearing pass.
// req.ready is low from acceptance until the item ends, after its last beat if any.
// ---------------------------------------------------------------------------
module node_health_monitor_table_core
   import nhm_pkg::*;
#(
   parameter int unsigned SLOTS = SLOTS_DEF
)(
   input  logic        clock,
   input  logic        reset,
   nhm_req_if.sink     req,
   nhm_rsp_if.source   rsp,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   cfg_type   cfg_ff;
   state_type state_ff, state_in;

   entry_type mem [SLOTS];
   logic [SLOTS-1:0] vld_ff;
   entry_type rd_ff;
   logic      rdv_ff;
   logic [IW-1:0] addr;

   logic [1:0]  op_ff;
   logic [31:0] id_ff;
   logic [15:0] cv_ff;
   logic [15:0] rb_ff;
   logic [31:0] now_ff;

   logic [IW-1:0] idx_ff;
   logic [IW-1:0] fidx_ff, eidx_ff, slot_ff;
   logic          found_ff, empty_ff, claim_ff, hit_ff;
   logic [2:0]    cs_ff;
   logic [7:0]    lt_ff;
   logic          lt;

   logic [2:0]  kind_ff [3];
   logic [15:0] arg_ff [3];
   logic [1:0]  num_ff, oidx_ff;
   logic [31:0] heard_ff;

   entry_type ent, nent;
   logic      hit_now, emp_now, accept, wr_en;
   logic [2:0]  nkind [3];
   logic [15:0] narg [3];
   logic [1:0]  nnum;
   logic [1:0]  simple, lvl0;

   assign accept = req.valid && req.ready;

   // ---------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{HIBERNATE_RST, CRITICAL_RST, WARNING_RST, HYST_RST,
                     RB_LIMIT_RST, RB_WINDOW_RST, SILENCE_RST};
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_HIBERNATE: cfg_ff.hibernate <= csr_wdata[15:0];
            CSR_CRITICAL:  cfg_ff.critical  <= csr_wdata[15:0];
            CSR_WARNING:   cfg_ff.warning   <= csr_wdata[15:0];
            CSR_HYST:      cfg_ff.hyst      <= csr_wdata[15:0];
            CSR_RB_LIMIT:  cfg_ff.rb_limit  <= csr_wdata[15:0];
            CSR_RB_WINDOW: cfg_ff.rb_window <= csr_wdata;
            CSR_SILENCE:   cfg_ff.silence   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- slot memory
   assign addr = (state_ff == ST_SCAN_RD) ? idx_ff : slot_ff;

   always_ff @(posedge clock) begin
      rd_ff <= mem[addr];
      if (wr_en) begin
         mem[slot_ff] <= nent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rdv_ff <= 1'b0;
      end else begin
         rdv_ff <= vld_ff[addr];
         if (wr_en) begin
            vld_ff[slot_ff] <= 1'b1;
         end
      end
   end

   always_comb begin
      ent = rdv_ff ? rd_ff : '0;
      if (claim_ff) begin
         ent      = '0;
         ent.node = id_ff;
      end
   end

   assign hit_now = rdv_ff && (rd_ff.node == id_ff);
   assign emp_now = !rdv_ff || (rd_ff.node == 32'd0);

   nhm_cmp u_cmp (
      .step (cs_ff),
      .cfg  (cfg_ff),
      .cv   (cv_ff),
      .rb   (rb_ff),
      .now  (now_ff),
      .ent  (ent),
      .lt   (lt)
   );

   // ---------------- update of one slot and the result list
   always_comb begin
      nent = ent;
      nnum = 2'd0;
      wr_en = 1'b0;
      for (int k = 0; k < 3; k++) begin
         nkind[k] = KIND_QUERY;
         narg[k]  = 16'd0;
      end
      simple = lt_ff[CS_HIB] ? 2'd3 : lt_ff[CS_CRIT] ? 2'd2 : lt_ff[CS_WARN] ? 2'd1 : 2'd0;
      lvl0 = ent.seen ? ent.level : simple;
      if (state_ff == ST_EVAL) begin
         unique case (op_ff)
            OP_HEARTBEAT: begin
               wr_en = 1'b1;
               nent.heard  = now_ff;
               nent.seen   = 1'b1;
               nent.silent = 1'b0;
               nent.level  = lvl0;
               if (ent.seen && ent.silent) begin
                  nkind[nnum] = KIND_ONLINE;
                  nnum = nnum + 2'd1;
               end
               if (simple > lvl0) begin
                  nent.level = simple;
                  nkind[nnum] = 3'd1 + {1'b0, simple};
                  narg[nnum]  = cv_ff;
                  nnum = nnum + 2'd1;
               end else if (lvl0 != 2'd0) begin
                  if (!lt_ff[CS_WARN_UP]) begin
                     nent.level = 2'd0;
                     nkind[nnum] = KIND_RECOVERED;
                     narg[nnum]  = cv_ff;
                     nnum = nnum + 2'd1;
                  end else if (lvl0 >= 2'd2 && !lt_ff[CS_CRIT_UP]) begin
                     nent.level = lvl0 - 2'd1;
                  end
               end
               if (lt_ff[CS_WINDOW] || ent.rb_base == 16'd0) begin
                  nent.win_start = now_ff;
                  nent.rb_base   = rb_ff;
                  nent.anom      = 1'b0;
               end else if (lt_ff[CS_REBOOT] && !ent.anom) begin
                  nent.anom = 1'b1;
                  nkind[nnum] = KIND_REBOOT;
                  narg[nnum]  = rb_ff;
                  nnum = nnum + 2'd1;
               end
            end
            OP_SILENCE: begin
               if (ent.seen && !ent.silent && lt_ff[CS_SILENCE]) begin
                  wr_en = 1'b1;
                  nent.silent = 1'b1;
                  nkind[0] = KIND_SILENT;
                  nnum = 2'd1;
               end
            end
            OP_QUERY: begin
               nnum = 2'd1;
            end
            default: ;
         endcase
      end
   end

   // ---------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid && req.node_id != 32'd0 &&
                (req.opcode == OP_HEARTBEAT || req.opcode == OP_SILENCE ||
                 req.opcode == OP_QUERY)) begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            if (idx_ff != LAST_IDX) begin
               state_in = ST_SCAN_RD;
            end else if (found_ff || hit_now) begin
               state_in = ST_FETCH;
            end else if (op_ff == OP_QUERY) begin
               state_in = ST_EVAL;
            end else if (op_ff == OP_HEARTBEAT && (empty_ff || emp_now)) begin
               state_in = ST_FETCH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: state_in = ST_CMP;
         ST_CMP: begin
            if (cs_ff == CS_SILENCE) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: state_in = (nnum != 2'd0) ? ST_EMIT : ST_IDLE;
         ST_EMIT: begin
            rsp.valid = 1'b1;
            if (rsp.ready && oidx_ff == num_ff - 2'd1) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req.opcode;
         id_ff    <= req.node_id;
         cv_ff    <= req.battery_cv;
         rb_ff    <= req.reboot_total;
         now_ff   <= req.now_ms;
         idx_ff   <= '0;
         found_ff <= 1'b0;
         empty_ff <= 1'b0;
         claim_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end
      if (state_ff == ST_SCAN_CMP) begin
         idx_ff <= idx_ff + IW'(1);
         // keep the first match and the first free slot
         if (hit_now && !found_ff) begin
            found_ff <= 1'b1;
            fidx_ff  <= idx_ff;
         end
         if (emp_now && !empty_ff) begin
            empty_ff <= 1'b1;
            eidx_ff  <= idx_ff;
         end
         if (idx_ff == LAST_IDX) begin
            if (found_ff) begin
               slot_ff <= fidx_ff;
               hit_ff  <= 1'b1;
            end else if (hit_now) begin
               slot_ff <= idx_ff;
               hit_ff  <= 1'b1;
            end else if (empty_ff) begin
               slot_ff  <= eidx_ff;
               claim_ff <= 1'b1;
            end else begin
               slot_ff  <= idx_ff;
               claim_ff <= 1'b1;
            end
         end
      end
      if (state_ff == ST_FETCH) begin
         cs_ff <= CS_HIB;
      end
      if (state_ff == ST_CMP) begin
         lt_ff[cs_ff] <= lt;
         cs_ff <= cs_ff + 3'd1;
      end
      if (state_ff == ST_EVAL) begin
         kind_ff  <= nkind;
         arg_ff   <= narg;
         num_ff   <= nnum;
         oidx_ff  <= 2'd0;
         heard_ff <= (op_ff == OP_QUERY && hit_ff) ? ent.heard : 32'd0;
      end
      if (state_ff == ST_EMIT && rsp.ready) begin
         oidx_ff <= oidx_ff + 2'd1;
      end
   end

   assign rsp.alert_kind    = kind_ff[oidx_ff];
   assign rsp.alert_node    = id_ff;
   assign rsp.alert_arg     = arg_ff[oidx_ff];
   assign rsp.alert_time_ms = now_ff;
   assign rsp.heard_ms      = heard_ff;
   assign rsp.last_of_run   = (oidx_ff == num_ff - 2'd1);

`ifndef SYNTH
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("result beat while request side open");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (accept && state_in != ST_IDLE) |=> !req.ready)
      else $error("ready high during item work");
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (num_ff != 2'd0 && oidx_ff < num_ff))
      else $error("beat index out of range");
   a_write_slot_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> vld_ff[$past(slot_ff)])
      else $error("written slot not marked valid");
`endif

endmodule

// ----- bench/nhm_table_checker.sv -----
// ---------------------------------------------------------------------------
// nhm_table_checker
// Watches the request and alert channels, predicts the alert beats of each
// accepted request from its own model of the slot table, and compares them.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module nhm_table_checker
   import nhm_pkg::*;
#(
   parameter int unsigned SLOTS = SLOTS_DEF
)(
   input  logic        clock,
   input  logic        reset,
   nhm_req_if.sink     req_mon,
   nhm_rsp_if.sink     rsp_mon,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          alerts_pending
);

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] node;
      logic [15:0] arg;
      logic [31:0] at_ms;
      logic [31:0] heard;
      logic        last;
   } alert_type;

   cfg_type     cfg;
   entry_type   table_q [SLOTS];
   alert_type   alert_fifo [$];

   assign alerts_pending = alert_fifo.size();

   function automatic int find_slot(logic [31:0] id);
      for (int i = 0; i < SLOTS; i++)
         if (table_q[i].node == id) return i;
      return -1;
   endfunction

   function automatic logic [1:0] battery_level(logic [15:0] cv);
      if (cv < cfg.hibernate) return 2'd3;
      if (cv < cfg.critical)  return 2'd2;
      if (cv < cfg.warning)   return 2'd1;
      return 2'd0;
   endfunction

   task automatic push_alert(logic [2:0] kind, logic [31:0] id, logic [15:0] arg,
                             logic [31:0] at_ms, logic [31:0] heard);
      alert_type a;
      a.kind = kind; a.node = id; a.arg = arg; a.at_ms = at_ms;
      a.heard = heard; a.last = 1'b0;
      alert_fifo.push_back(a);
   endtask

   task automatic apply_request(logic [1:0] op, logic [31:0] id, logic [15:0] cv,
                                logic [15:0] rb, logic [31:0] now_ms);
      int s;
      int before_n;
      logic [1:0] lvl;
      logic [16:0] warn_up, crit_up;
      logic [15:0] delta;
      before_n = alert_fifo.size();
      if (id == 0) return;
      s = find_slot(id);
      if (op == OP_HEARTBEAT) begin
         if (s < 0) begin
            s = find_slot(32'd0);
            if (s < 0) return;
            table_q[s].node = id;
            table_q[s].level = 2'd0;
            table_q[s].silent = 1'b0;
            table_q[s].seen = 1'b0;
         end
         lvl = battery_level(cv);
         warn_up = {1'b0, cfg.warning} + {1'b0, cfg.hyst};
         crit_up = {1'b0, cfg.critical} + {1'b0, cfg.hyst};
         table_q[s].heard = now_ms;
         if (!table_q[s].seen) begin
            table_q[s].seen = 1'b1;
            table_q[s].silent = 1'b0;
            table_q[s].level = lvl;
         end else if (table_q[s].silent) begin
            table_q[s].silent = 1'b0;
            push_alert(KIND_ONLINE, id, 16'd0, now_ms, 32'd0);
         end
         if (lvl > table_q[s].level) begin
            table_q[s].level = lvl;
            push_alert(3'd1 + 3'(lvl), id, cv, now_ms, 32'd0);
         end else if (table_q[s].level != 0) begin
            if ({1'b0, cv} >= warn_up) begin
               table_q[s].level = 2'd0;
               push_alert(KIND_RECOVERED, id, cv, now_ms, 32'd0);
            end else if (table_q[s].level >= 2 && {1'b0, cv} >= crit_up) begin
               table_q[s].level = table_q[s].level - 2'd1;
            end
         end
         if ((now_ms - table_q[s].win_start) > cfg.rb_window || table_q[s].rb_base == 0)
         begin
            table_q[s].win_start = now_ms;
            table_q[s].rb_base = rb;
            table_q[s].anom = 1'b0;
         end else begin
            delta = rb - table_q[s].rb_base;
            if (delta > cfg.rb_limit && !table_q[s].anom) begin
               table_q[s].anom = 1'b1;
               push_alert(KIND_REBOOT, id, rb, now_ms, 32'd0);
            end
         end
      end else if (op == OP_SILENCE) begin
         if (s >= 0 && table_q[s].seen && !table_q[s].silent &&
             (now_ms - table_q[s].heard) > cfg.silence) begin
            table_q[s].silent = 1'b1;
            push_alert(KIND_SILENT, id, 16'd0, now_ms, 32'd0);
         end
      end else if (op == OP_QUERY) begin
         push_alert(KIND_QUERY, id, 16'd0, now_ms, s >= 0 ? table_q[s].heard : 32'd0);
      end
      if (alert_fifo.size() > before_n)
         alert_fifo[alert_fifo.size() - 1].last = 1'b1;
   endtask

   task automatic compare_alert();
      alert_type e;
      if (alert_fifo.size() == 0) begin
         $error("alert beat with nothing expected: kind %0d node %0h",
                rsp_mon.alert_kind, rsp_mon.alert_node);
         fail_count++;
         return;
      end
      e = alert_fifo.pop_front();
      if (rsp_mon.alert_kind !== e.kind) begin
         $error("alert_kind expected %0d actual %0d", e.kind, rsp_mon.alert_kind);
         fail_count++;
      end
      if (rsp_mon.alert_node !== e.node) begin
         $error("alert_node expected %0h actual %0h", e.node, rsp_mon.alert_node);
         fail_count++;
      end
      if (rsp_mon.alert_arg !== e.arg) begin
         $error("alert_arg expected %0d actual %0d", e.arg, rsp_mon.alert_arg);
         fail_count++;
      end
      if (rsp_mon.alert_time_ms !== e.at_ms) begin
         $error("alert_time_ms expected %0d actual %0d", e.at_ms, rsp_mon.alert_time_ms);
         fail_count++;
      end
      if (rsp_mon.heard_ms !== e.heard) begin
         $error("heard_ms expected %0d actual %0d", e.heard, rsp_mon.heard_ms);
         fail_count++;
      end
      if (rsp_mon.last_of_run !== e.last) begin
         $error("last_of_run expected %0d actual %0d", e.last, rsp_mon.last_of_run);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg = '{HIBERNATE_RST, CRITICAL_RST, WARNING_RST, HYST_RST, RB_LIMIT_RST,
                 RB_WINDOW_RST, SILENCE_RST};
         for (int i = 0; i < SLOTS; i++) table_q[i] = '0;
         alert_fifo.delete();
         fail_count = 0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_HIBERNATE: cfg.hibernate = csr_wdata[15:0];
               CSR_CRITICAL:  cfg.critical  = csr_wdata[15:0];
               CSR_WARNING:   cfg.warning   = csr_wdata[15:0];
               CSR_HYST:      cfg.hyst      = csr_wdata[15:0];
               CSR_RB_LIMIT:  cfg.rb_limit  = csr_wdata[15:0];
               CSR_RB_WINDOW: cfg.rb_window = csr_wdata;
               CSR_SILENCE:   cfg.silence   = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) compare_alert();
         if (req_mon.valid && req_mon.ready)
            apply_request(req_mon.opcode, req_mon.node_id, req_mon.battery_cv,
                          req_mon.reboot_total, req_mon.now_ms);
      end
   end

   final begin
      if (alert_fifo.size() != 0)
         $error("%0d alert beats never arrived", alert_fifo.size());
   end

endmodule

// ----- bench/node_health_monitor_table_core_tb.sv -----
// ---------------------------------------------------------------------------
// node_health_monitor_table_core_tb
// Drives heartbeats, silence checks and queries into the slot table under
// several threshold settings and idle patterns; the checker grades beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module node_health_monitor_table_core_tb;
   import nhm_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   int          fail_count;
   int          alerts_pending;
   int          idle_cycles = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   logic [31:0] clock_ms = 32'd1000;
   logic [31:0] node_pool [8];

   nhm_req_if req ();
   nhm_rsp_if rsp ();

   node_health_monitor_table_core dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata));

   nhm_table_checker chk (
      .clock(clock), .reset(reset), .req_mon(req.sink), .rsp_mon(rsp.sink),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .alerts_pending(alerts_pending));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0; req.opcode = '0; req.node_id = '0;
      req.battery_cv = '0; req.reboot_total = '0; req.now_ms = '0;
      rsp.ready = 1'b0;
   end

   // receiver stall pattern, changed at the falling edge
   always @(negedge clock)
      rsp.ready <= !reset && ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // the accepted request stays on the bus past the accepting edge only until the next falling edge
   task automatic send(logic [1:0] op, logic [31:0] id, logic [15:0] cv,
                       logic [15:0] rb, logic [31:0] now_ms);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.opcode <= op; req.node_id <= id; req.battery_cv <= cv;
      req.reboot_total <= rb; req.now_ms <= now_ms;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      while (alerts_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [31:0] value);
      csr_wen <= 1'b1; csr_index <= idx; csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic set_thresholds(logic [15:0] hib, logic [15:0] crit, logic [15:0] warn,
                                 logic [15:0] hyst, logic [15:0] rlim, logic [31:0] rwin,
                                 logic [31:0] sil);
      wait_idle();
      write_csr(CSR_HIBERNATE, hib);
      write_csr(CSR_CRITICAL, crit);
      write_csr(CSR_WARNING, warn);
      write_csr(CSR_HYST, hyst);
      write_csr(CSR_RB_LIMIT, rlim);
      write_csr(CSR_RB_WINDOW, rwin);
      write_csr(CSR_SILENCE, sil);
   endtask

   // one random beat, mostly heartbeats from a small node pool with a sane clock
   task automatic random_request();
      logic [1:0]  op;
      logic [31:0] id;
      logic [15:0] cv;
      logic [31:0] now_ms;
      int pick;
      pick = $urandom_range(99);
      op = (pick < 55) ? OP_HEARTBEAT : (pick < 75) ? OP_SILENCE :
           (pick < 95) ? OP_QUERY : OP_RESERVED;
      id = ($urandom_range(19) == 0) ? $urandom : node_pool[$urandom_range(7)];
      if ($urandom_range(29) == 0) id = 32'd0;
      cv = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(420, 300));
      clock_ms = clock_ms + (($urandom_range(3) == 0) ? $urandom_range(2000000)
                                                      : $urandom_range(50000));
      now_ms = ($urandom_range(24) == 0) ? $urandom : clock_ms;
      send(op, id, cv, 16'($urandom_range(40)), now_ms);
   endtask

   initial begin
      for (int i = 0; i < 8; i++)
         node_pool[i] = (i < 6) ? 32'h1001 + 32'(i) : ($urandom | 32'h1);
      node_pool[0] = 32'hFFFF_FFFF;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: new node, drops, recovery, silence, back online, anomaly
      send(OP_QUERY, 32'd7, 16'd0, 16'd0, 32'd5);
      send(OP_HEARTBEAT, 32'd7, 16'd400, 16'd1, 32'd10);
      send(OP_HEARTBEAT, 32'd7, 16'd355, 16'd2, 32'd20);
      send(OP_HEARTBEAT, 32'd7, 16'd335, 16'd3, 32'd30);
      send(OP_HEARTBEAT, 32'd7, 16'd0, 16'd4, 32'd40);
      send(OP_HEARTBEAT, 32'd7, 16'd345, 16'd5, 32'd50);
      send(OP_HEARTBEAT, 32'd7, 16'hFFFF, 16'd20, 32'd60);
      send(OP_SILENCE, 32'd7, 16'd0, 16'd0, 32'd70);
      send(OP_SILENCE, 32'd7, 16'd0, 16'd0, 32'd700000);
      send(OP_SILENCE, 32'd7, 16'd0, 16'd0, 32'd800000);
      send(OP_HEARTBEAT, 32'd7, 16'd300, 16'd40, 32'd900000);
      send(OP_QUERY, 32'd7, 16'd0, 16'd0, 32'hFFFF_FFFF);
      send(OP_SILENCE, 32'd9, 16'd0, 16'd0, 32'd900000);
      send(OP_HEARTBEAT, 32'd0, 16'd100, 16'd1, 32'd1);
      send(OP_RESERVED, 32'd7, 16'd100, 16'd1, 32'd1);
      // fill the table; the last node of the loop and one more unknown node are dropped
      for (int i = 1; i <= 16; i++)
         send(OP_HEARTBEAT, 32'h1000 + i, 16'd380, 16'hFFFF, 32'd100);
      send(OP_HEARTBEAT, 32'h2000, 16'd380, 16'd1, 32'd100);

      // fresh table would need a reset; keep it and vary the settings instead
      set_thresholds(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 32'd1, 32'd0);
      for (int i = 0; i < 8; i++) send(OP_HEARTBEAT, 32'h1001 + i, 16'($urandom),
                                       16'($urandom), 32'(i * 3));
      set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF);
      for (int i = 0; i < 4; i++) send(OP_SILENCE, 32'h1001 + i, 16'd0, 16'd0, $urandom);
      set_thresholds(16'd330, 16'd360, 16'd340, 16'd10, 16'd5, 32'd86400000, 32'd600000);

      // random phases over the pool of known ids
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 78; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 78; end
            default: begin send_idle_pct = 25; stall_pct = 25; end
         endcase
         if (ph == 2)
            set_thresholds(16'($urandom_range(340, 300)), 16'($urandom_range(360, 320)),
                           16'($urandom_range(400, 340)), 16'($urandom_range(30)),
                           16'($urandom_range(10)), $urandom_range(5000000, 1),
                           $urandom_range(3000000));
         for (int n = 0; n < 40; n++) begin
            random_request();
            if (n == 20) wait_idle();
         end
      end

      wait_idle();
      if (fail_count == 0 && alerts_pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/nhm_pkg.sv
design/nhm_req_if.sv
design/nhm_rsp_if.sv
design/nhm_cmp.sv
design/node_health_monitor_table_core.sv
bench/nhm_table_checker.sv
bench/node_health_monitor_table_core_tb.sv
